// File: sv/mox_pkg.sv
// Shared types and constants for the macro-op expander.
// Used by the front, queue, back and top-level modules; no dependencies.
package mox_pkg;

  // Request opcodes as they arrive on the input channel
  typedef enum logic [2:0] {
    OP_MOVE       = 3'd0,
    OP_COMPLEMENT = 3'd1,
    OP_NEGATE     = 3'd2,
    OP_SUBTRACT   = 3'd3,
    OP_AND        = 3'd4,
    OP_OR         = 3'd5,
    OP_LOAD_LIT   = 3'd6,
    OP_NONE       = 3'd7
  } req_op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOAD_VALUE = 2'd0,
    CFG_ADD        = 2'd1,
    CFG_NAND       = 2'd2,
    CFG_MULTIPLY   = 2'd3
  } cfg_idx_t;

  // Word sequences the back end knows how to play out
  typedef enum logic [3:0] {
    SEQ_MOVE,
    SEQ_NOT,
    SEQ_NEG,
    SEQ_NEG_MISS,
    SEQ_SUB_ZERO,
    SEQ_SUB,
    SEQ_AND,
    SEQ_OR_BC,
    SEQ_OR,
    SEQ_LIT,
    SEQ_LIT_SPLIT,
    SEQ_MISSING
  } seq_kind_t;

  // One classified request: sequence, register operands, literal, final step
  typedef struct packed {
    seq_kind_t   kind;
    logic [2:0]  a;
    logic [2:0]  b;
    logic [2:0]  c;
    logic [2:0]  t;
    logic [31:0] lit;
    logic [2:0]  last_step;
  } seq_desc_t;

  // Opcode fields placed in emitted words
  typedef struct packed {
    logic [3:0] lv_code;
    logic [3:0] add_code;
    logic [3:0] nand_code;
    logic [3:0] mul_code;
  } op_codes_t;

  localparam logic [3:0]  RST_CODE_LOAD_VALUE = 4'd13;
  localparam logic [3:0]  RST_CODE_ADD        = 4'd3;
  localparam logic [3:0]  RST_CODE_NAND       = 4'd6;
  localparam logic [3:0]  RST_CODE_MULTIPLY   = 4'd4;

  localparam int unsigned MOX_QUEUE_DEPTH = 2;
  localparam int unsigned MOX_ADDR_W      = 4;

  // Literal fits the 25-bit load-value field below this bound
  localparam logic [31:0] LIT_LIMIT    = 32'h0200_0000;
  // Scale factor for the split literal form (1 << 7)
  localparam logic [24:0] LIT_SCALE    = 25'd128;
  localparam int unsigned LIT_LOW_BITS = 7;

endpackage

// File: sv/macro_op_expander_unit.sv
// Macro-op expander: one request in, a run of 0 to 7 machine words out.
// A request goes through the front register and the queue to the sequencer.
// Throughput: one word per cycle while the word port is ready; a request holds the
// back-end sequencer until the last word of its run leaves.
// Requests with no words are dropped in the front end and never reach the back end.
// Reset (synchronous, active low) empties all stages and loads the default opcodes.
module macro_op_expander_unit
  import mox_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = MOX_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MOX_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [2:0]            in_reg_a,
  input  logic [2:0]            in_reg_b,
  input  logic [2:0]            in_reg_c,
  input  logic [2:0]            in_temp_reg,
  input  logic                  in_temp_given,
  input  logic [31:0]           in_literal,
  // Word channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_word,
  output logic                  out_last,
  output logic                  out_missing_temp
);

  op_codes_t codes_r, codes_nxt;
  cfg_idx_t  cfg_idx;
  logic      cfg_write;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  seq_desc_t push_desc, pop_desc;

  // Decode register writes
  assign pready    = 1'b1;
  assign cfg_idx   = cfg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_write) begin
      case (cfg_idx)
        CFG_LOAD_VALUE: codes_nxt.lv_code   = pwdata[3:0];
        CFG_ADD:        codes_nxt.add_code  = pwdata[3:0];
        CFG_NAND:       codes_nxt.nand_code = pwdata[3:0];
        CFG_MULTIPLY:   codes_nxt.mul_code  = pwdata[3:0];
        default:        codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.lv_code   <= RST_CODE_LOAD_VALUE;
      codes_r.add_code  <= RST_CODE_ADD;
      codes_r.nand_code <= RST_CODE_NAND;
      codes_r.mul_code  <= RST_CODE_MULTIPLY;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  // Read back the selected register
  always_comb begin
    case (cfg_idx)
      CFG_LOAD_VALUE: prdata = {28'd0, codes_r.lv_code};
      CFG_ADD:        prdata = {28'd0, codes_r.add_code};
      CFG_NAND:       prdata = {28'd0, codes_r.nand_code};
      CFG_MULTIPLY:   prdata = {28'd0, codes_r.mul_code};
      default:        prdata = '0;
    endcase
  end

  mox_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_reg_a      (in_reg_a),
    .in_reg_b      (in_reg_b),
    .in_reg_c      (in_reg_c),
    .in_temp_reg   (in_temp_reg),
    .in_temp_given (in_temp_given),
    .in_literal    (in_literal),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_desc     (push_desc)
  );

  mox_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  mox_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .codes            (codes_r),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_desc         (pop_desc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word),
    .out_last         (out_last),
    .out_missing_temp (out_missing_temp)
  );

endmodule

// File: sv/mox_front.sv
// Front end of the macro-op expander: accepts requests and classifies them.
// Depends on mox_pkg; feeds mox_queue.
module mox_front
  import mox_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_reg_a,
  input  logic [2:0]  in_reg_b,
  input  logic [2:0]  in_reg_c,
  input  logic [2:0]  in_temp_reg,
  input  logic        in_temp_given,
  input  logic [31:0] in_literal,
  output logic        push_valid,
  input  logic        push_ready,
  output seq_desc_t   push_desc
);

  logic      front_valid_r, front_valid_nxt;
  seq_desc_t desc_r;
  seq_desc_t desc_c;
  logic      emit_c;
  logic      eq_ab, eq_bc, eq_ac;
  logic      in_fire;
  logic [31:0] lit_inv;

  assign eq_ab   = (in_reg_a == in_reg_b);
  assign eq_bc   = (in_reg_b == in_reg_c);
  assign eq_ac   = (in_reg_a == in_reg_c);
  assign lit_inv = ~in_literal;

  // Classify the request into a sequence and its operands
  always_comb begin
    emit_c           = 1'b1;
    desc_c.kind      = SEQ_MISSING;
    desc_c.a         = in_reg_a;
    desc_c.b         = in_reg_b;
    desc_c.c         = in_reg_c;
    desc_c.t         = in_temp_reg;
    desc_c.lit       = in_literal;
    desc_c.last_step = 3'd0;
    case (req_op_t'(in_opcode))
      OP_MOVE: begin
        emit_c           = !eq_ab;
        desc_c.kind      = SEQ_MOVE;
        desc_c.last_step = 3'd1;
      end
      OP_COMPLEMENT: begin
        desc_c.kind = SEQ_NOT;
      end
      OP_NEGATE: begin
        if (eq_ab && !in_temp_given) begin
          desc_c.kind      = SEQ_NEG_MISS;
          desc_c.last_step = 3'd1;
        end else begin
          desc_c.kind      = SEQ_NEG;
          desc_c.t         = eq_ab ? in_temp_reg : in_reg_b;
          desc_c.last_step = 3'd2;
        end
      end
      OP_SUBTRACT: begin
        if (eq_bc) begin
          desc_c.kind = SEQ_SUB_ZERO;
        end else if (eq_ab || eq_ac) begin
          if (!in_temp_given) begin
            desc_c.kind = SEQ_MISSING;
          end else begin
            desc_c.kind      = SEQ_SUB;
            desc_c.last_step = eq_ab ? 3'd4 : 3'd3;
          end
        end else begin
          desc_c.kind      = SEQ_SUB;
          desc_c.t         = in_reg_a;
          desc_c.last_step = 3'd4;
        end
      end
      OP_AND: begin
        desc_c.kind      = SEQ_AND;
        desc_c.last_step = 3'd1;
      end
      OP_OR: begin
        if (eq_ab && eq_bc) begin
          emit_c = 1'b0;
        end else if (eq_bc) begin
          desc_c.kind      = SEQ_OR_BC;
          desc_c.last_step = 3'd2;
        end else begin
          // t names the register complemented again on the fourth word
          desc_c.kind      = SEQ_OR;
          desc_c.t         = eq_ab ? in_reg_c : in_reg_b;
          desc_c.last_step = (eq_ab || eq_ac) ? 3'd3 : 3'd4;
        end
      end
      OP_LOAD_LIT: begin
        if (in_literal < LIT_LIMIT) begin
          desc_c.kind = SEQ_LIT;
        end else if (lit_inv < LIT_LIMIT) begin
          desc_c.kind      = SEQ_LIT;
          desc_c.lit       = lit_inv;
          desc_c.last_step = 3'd1;
        end else if (!in_temp_given) begin
          desc_c.kind = SEQ_MISSING;
        end else begin
          desc_c.kind      = SEQ_LIT_SPLIT;
          desc_c.last_step = 3'd6;
        end
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
  end

  // Hold a classified request until the queue takes it; drop empty runs
  assign in_ready   = !front_valid_r || push_ready;
  assign in_fire    = in_valid && in_ready;
  assign push_valid = front_valid_r;
  assign push_desc  = desc_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_fire) begin
      front_valid_nxt = emit_c;
    end else if (push_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      desc_r <= desc_c;
    end
  end

endmodule

// File: sv/mox_queue.sv
// Short queue of classified requests between front and back ends.
// Depends on mox_pkg for the descriptor type.
module mox_queue
  import mox_pkg::*;
#(
  parameter int unsigned DEPTH = MOX_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  seq_desc_t push_desc,
  output logic      pop_valid,
  input  logic      pop_ready,
  output seq_desc_t pop_desc
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  seq_desc_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: sv/mox_back.sv
// Back end of the macro-op expander: plays out one word per cycle unless the output stalls.
// Depends on mox_pkg; drains mox_queue and drives the output register.
module mox_back
  import mox_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  op_codes_t   codes,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  seq_desc_t   pop_desc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_last,
  output logic        out_missing_temp
);

  seq_desc_t   cur_r;
  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r;
  logic        out_last_r;
  logic        out_missing_r;
  logic [31:0] word_c;
  logic        missing_c;
  logic        adv, is_last, load;

  function automatic logic [31:0] plain_word(input logic [3:0] op, input logic [2:0] ra,
                                             input logic [2:0] rb, input logic [2:0] rc);
    plain_word = {op, 19'd0, ra, rb, rc};
  endfunction

  function automatic logic [31:0] lv_word(input logic [3:0] op, input logic [2:0] ra,
                                          input logic [24:0] v);
    lv_word = {op, ra, v};
  endfunction

  // Form the word for the current sequence and step
  always_comb begin
    word_c    = '0;
    missing_c = 1'b0;
    case (cur_r.kind)
      SEQ_MOVE: begin
        case (step_r)
          3'd0:    word_c = lv_word(codes.lv_code, cur_r.a, '0);
          default: word_c = plain_word(codes.add_code, cur_r.a, cur_r.a, cur_r.b);
        endcase
      end
      SEQ_NOT: begin
        word_c = plain_word(codes.nand_code, cur_r.a, cur_r.b, cur_r.b);
      end
      SEQ_NEG: begin
        case (step_r)
          3'd0:    word_c = plain_word(codes.nand_code, cur_r.a, cur_r.b, cur_r.b);
          3'd1:    word_c = lv_word(codes.lv_code, cur_r.t, 25'd1);
          default: word_c = plain_word(codes.add_code, cur_r.a, cur_r.a, cur_r.t);
        endcase
      end
      SEQ_NEG_MISS: begin
        case (step_r)
          3'd0:    word_c = plain_word(codes.nand_code, cur_r.a, cur_r.b, cur_r.b);
          default: missing_c = 1'b1;
        endcase
      end
      SEQ_SUB_ZERO: begin
        word_c = lv_word(codes.lv_code, cur_r.a, '0);
      end
      SEQ_SUB: begin
        case (step_r)
          3'd1:    word_c = lv_word(codes.lv_code, cur_r.t, 25'd1);
          3'd2:    word_c = plain_word(codes.add_code, cur_r.c, cur_r.t, cur_r.c);
          3'd3:    word_c = plain_word(codes.add_code, cur_r.a, cur_r.b, cur_r.c);
          default: word_c = plain_word(codes.nand_code, cur_r.c, cur_r.c, cur_r.c);
        endcase
      end
      SEQ_AND: begin
        case (step_r)
          3'd0:    word_c = plain_word(codes.nand_code, cur_r.b, cur_r.b, cur_r.c);
          default: word_c = plain_word(codes.nand_code, cur_r.a, cur_r.b, cur_r.b);
        endcase
      end
      SEQ_OR_BC: begin
        case (step_r)
          3'd1:    word_c = plain_word(codes.nand_code, cur_r.a, cur_r.c, cur_r.c);
          default: word_c = plain_word(codes.nand_code, cur_r.c, cur_r.c, cur_r.c);
        endcase
      end
      SEQ_OR: begin
        case (step_r)
          3'd0:    word_c = plain_word(codes.nand_code, cur_r.b, cur_r.b, cur_r.b);
          3'd2:    word_c = plain_word(codes.nand_code, cur_r.a, cur_r.b, cur_r.c);
          3'd3:    word_c = plain_word(codes.nand_code, cur_r.t, cur_r.t, cur_r.t);
          default: word_c = plain_word(codes.nand_code, cur_r.c, cur_r.c, cur_r.c);
        endcase
      end
      SEQ_LIT: begin
        case (step_r)
          3'd0:    word_c = lv_word(codes.lv_code, cur_r.a, cur_r.lit[24:0]);
          default: word_c = plain_word(codes.nand_code, cur_r.a, cur_r.a, cur_r.a);
        endcase
      end
      SEQ_LIT_SPLIT: begin
        case (step_r)
          3'd0:    word_c = lv_word(codes.lv_code, cur_r.t, LIT_SCALE);
          3'd1:    word_c = lv_word(codes.lv_code, cur_r.a, cur_r.lit[31:LIT_LOW_BITS]);
          3'd2:    word_c = plain_word(codes.mul_code, cur_r.a, cur_r.a, cur_r.t);
          3'd3:    word_c = lv_word(codes.lv_code, cur_r.t,
                                    {18'd0, cur_r.lit[LIT_LOW_BITS-1:0]});
          3'd4:    word_c = plain_word(codes.nand_code, cur_r.a, cur_r.a, cur_r.a);
          3'd5:    word_c = plain_word(codes.nand_code, cur_r.t, cur_r.t, cur_r.t);
          default: word_c = plain_word(codes.nand_code, cur_r.a, cur_r.a, cur_r.t);
        endcase
      end
      SEQ_MISSING: begin
        missing_c = 1'b1;
      end
      default: begin
        word_c = '0;
      end
    endcase
  end

  // Step the sequencer; take the next request as the last word leaves
  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign is_last   = (step_r == cur_r.last_step);
  assign load      = pop_valid && (!busy_r || (adv && is_last));
  assign pop_ready = load;

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      step_nxt      = step_r + 3'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= pop_desc;
    end
    if (adv) begin
      out_word_r    <= word_c;
      out_last_r    <= is_last;
      out_missing_r <= missing_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word         = out_word_r;
  assign out_last         = out_last_r;
  assign out_missing_temp = out_missing_r;

  // A missing-temporary result always closes its run with a zero word
  a_missing_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_missing_r) |-> (out_last_r && (out_word_r == '0)))
    else $error("missing-temporary result not final or not zero");

  // The step counter never runs past the final step of its sequence
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= cur_r.last_step))
    else $error("sequencer step beyond final step");

  // A new request is only taken when no run is left unfinished
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || (adv && is_last)))
    else $error("request loaded over an unfinished run");

  // Once the output holds a stalled word, the sequencer does not advance
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !adv)
    else $error("sequencer advanced into a stalled output");

endmodule

// File: verif/macro_op_expander_checker.sv
// Checker for the macro-op expander: watches the request, word and config ports,
// predicts each request's run of words and compares the words as they come out.
// Depends on mox_pkg for the opcode, register index and opcode-field types.
`timescale 1ns / 100ps

module macro_op_expander_checker
  import mox_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MOX_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [2:0]            in_reg_a,
  input  logic [2:0]            in_reg_b,
  input  logic [2:0]            in_reg_c,
  input  logic [2:0]            in_temp_reg,
  input  logic                  in_temp_given,
  input  logic [31:0]           in_literal,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [31:0]           out_word,
  input  logic                  out_last,
  input  logic                  out_missing_temp,
  output int                    fail_count,
  output int                    words_pending
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        missing_temp;
  } word_rec_t;

  word_rec_t expected_words[$];
  word_rec_t run_buf[7];
  int        run_len;
  op_codes_t codes;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  function automatic void put_word(logic [31:0] w, logic miss);
    run_buf[run_len] = {w, 1'b0, miss};
    run_len++;
  endfunction

  // op[31:28], A[8:6], B[5:3], C[2:0]
  function automatic void plain_word(logic [3:0] op, logic [2:0] a, logic [2:0] b,
                                     logic [2:0] c);
    put_word({op, 19'd0, a, b, c}, 1'b0);
  endfunction

  // op[31:28], A[27:25], value[24:0]
  function automatic void lv_word(logic [2:0] a, logic [24:0] v);
    put_word({codes.lv_code, a, v}, 1'b0);
  endfunction

  // Predict the word run of one request and queue it, last flag on the final word
  function automatic void expand_request(req_op_t op, logic [2:0] a, logic [2:0] b,
                                         logic [2:0] c, logic [2:0] t, logic tg,
                                         logic [31:0] lit);
    logic [31:0] inv;
    logic [2:0]  src;
    logic [3:0]  nd;
    logic [3:0]  ad;
    run_len = 0;
    inv     = ~lit;
    nd      = codes.nand_code;
    ad      = codes.add_code;
    case (op)
      OP_MOVE: begin
        if (a != b) begin
          lv_word(a, 25'd0);
          plain_word(ad, a, a, b);
        end
      end
      OP_COMPLEMENT: plain_word(nd, a, b, b);
      OP_NEGATE: begin
        plain_word(nd, a, b, b);
        if (a == b && !tg) begin
          put_word(32'd0, 1'b1);
        end else begin
          src = (a == b) ? t : b;
          lv_word(src, 25'd1);
          plain_word(ad, a, a, src);
        end
      end
      OP_SUBTRACT: begin
        if (b == c) begin
          lv_word(a, 25'd0);
        end else if (a == b || a == c) begin
          if (!tg) begin
            put_word(32'd0, 1'b1);
          end else begin
            plain_word(nd, c, c, c);
            lv_word(t, 25'd1);
            plain_word(ad, c, t, c);
            plain_word(ad, a, b, c);
            if (a == b) plain_word(nd, c, c, c);
          end
        end else begin
          plain_word(nd, c, c, c);
          lv_word(a, 25'd1);
          plain_word(ad, c, a, c);
          plain_word(ad, a, b, c);
          plain_word(nd, c, c, c);
        end
      end
      OP_AND: begin
        plain_word(nd, b, b, c);
        plain_word(nd, a, b, b);
      end
      OP_OR: begin
        if (a == b && b == c) begin
          // nothing to emit
        end else if (b == c) begin
          plain_word(nd, c, c, c);
          plain_word(nd, a, c, c);
          plain_word(nd, c, c, c);
        end else begin
          plain_word(nd, b, b, b);
          plain_word(nd, c, c, c);
          plain_word(nd, a, b, c);
          if (a == b) begin
            plain_word(nd, c, c, c);
          end else if (a == c) begin
            plain_word(nd, b, b, b);
          end else begin
            plain_word(nd, b, b, b);
            plain_word(nd, c, c, c);
          end
        end
      end
      OP_LOAD_LIT: begin
        if (lit < LIT_LIMIT) begin
          lv_word(a, lit[24:0]);
        end else if (inv < LIT_LIMIT) begin
          lv_word(a, inv[24:0]);
          plain_word(nd, a, a, a);
        end else if (!tg) begin
          put_word(32'd0, 1'b1);
        end else begin
          // high part times 128, then merge the 7-bit low part through nands
          lv_word(t, LIT_SCALE);
          lv_word(a, lit[31:LIT_LOW_BITS]);
          plain_word(codes.mul_code, a, a, t);
          lv_word(t, {18'd0, lit[LIT_LOW_BITS-1:0]});
          plain_word(nd, a, a, a);
          plain_word(nd, t, t, t);
          plain_word(nd, a, a, t);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < run_len; i++) begin
      run_buf[i].last = (i == run_len - 1);
      expected_words.push_back(run_buf[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    word_rec_t want;
    if (!rst_n) begin
      codes.lv_code   = RST_CODE_LOAD_VALUE;
      codes.add_code  = RST_CODE_ADD;
      codes.nand_code = RST_CODE_NAND;
      codes.mul_code  = RST_CODE_MULTIPLY;
      expected_words.delete();
    end else begin
      // Compare each accepted word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("word %0h arrived with nothing predicted", out_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("word", want.word, out_word);
          check_field("last", 32'(want.last), 32'(out_last));
          check_field("missing_temp", 32'(want.missing_temp), 32'(out_missing_temp));
        end
      end
      // Track opcode-field register writes
      if (psel && penable && pwrite && pready) begin
        case (cfg_idx_t'(paddr[3:2]))
          CFG_LOAD_VALUE: codes.lv_code   = pwdata[3:0];
          CFG_ADD:        codes.add_code  = pwdata[3:0];
          CFG_NAND:       codes.nand_code = pwdata[3:0];
          CFG_MULTIPLY:   codes.mul_code  = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expand_request(req_op_t'(in_opcode), in_reg_a, in_reg_b, in_reg_c, in_temp_reg,
                       in_temp_given, in_literal);
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// File: verif/macro_op_expander_unit_tb.sv
// Top of the macro-op expander testbench: clock, reset, request and config stimulus,
// random stalls on the word port, and the final verdict.
// Depends on mox_pkg, macro_op_expander_unit and macro_op_expander_checker.
`timescale 1ns / 100ps

module macro_op_expander_unit_tb;
  import mox_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 85;
  localparam int DRAIN_CYCLES = 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [MOX_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_opcode;
  logic [2:0]            in_reg_a;
  logic [2:0]            in_reg_b;
  logic [2:0]            in_reg_c;
  logic [2:0]            in_temp_reg;
  logic                  in_temp_given;
  logic [31:0]           in_literal;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           out_word;
  logic                  out_last;
  logic                  out_missing_temp;
  int                    fail_count;
  int                    words_pending;
  int                    cycle_count;
  bit                    calm = 1'b0;

  macro_op_expander_unit u_top (.*);

  macro_op_expander_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop on a hang
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Word port backpressure: stall bursts alternating with ready stretches
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_codes(logic [3:0] lv, logic [3:0] add, logic [3:0] nd, logic [3:0] mul);
    cfg_write(CFG_LOAD_VALUE, {28'd0, lv});
    cfg_write(CFG_ADD, {28'd0, add});
    cfg_write(CFG_NAND, {28'd0, nd});
    cfg_write(CFG_MULTIPLY, {28'd0, mul});
  endtask

  // Present one request, hold it until accepted; returns in the accepting step
  task automatic send_request(req_op_t op, logic [2:0] a, logic [2:0] b, logic [2:0] c,
                              logic [2:0] t, logic tg, logic [31:0] lit);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_reg_a      <= a;
    in_reg_b      <= b;
    in_reg_c      <= c;
    in_temp_reg   <= t;
    in_temp_given <= tg;
    in_literal    <= lit;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted word, then let dropped requests clear
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_request();
    req_op_t     op;
    logic [2:0]  a;
    logic [2:0]  b;
    logic [2:0]  c;
    logic [2:0]  t;
    logic        tg;
    logic [31:0] lit;
    int          pick;
    op = ($urandom_range(0, 15) == 0) ? OP_NONE : req_op_t'($urandom_range(0, 6));
    a  = 3'($urandom_range(0, 7));
    b  = 3'($urandom_range(0, 7));
    c  = 3'($urandom_range(0, 7));
    t  = 3'($urandom_range(0, 7));
    // lean on register equalities, they pick the alternate sequences
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      b = a;
    end else if (pick == 1) begin
      c = a;
    end else if (pick == 2) begin
      c = b;
    end else if (pick == 3) begin
      b = a;
      c = a;
    end
    tg = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 4))
      0: lit = $urandom_range(0, LIT_LIMIT - 1);
      1: lit = ~32'($urandom_range(0, LIT_LIMIT - 1));
      2: begin
        lit = LIT_LIMIT - 1 + $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) lit = ~lit;
      end
      default: lit = $urandom;
    endcase
    send_request(op, a, b, c, t, tg, lit);
  endtask

  task automatic run_directed();
    send_request(OP_MOVE, 3'd1, 3'd2, 3'd0, 3'd0, 1'b0, 32'd0);
    send_request(OP_MOVE, 3'd3, 3'd3, 3'd5, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_NONE, 3'd7, 3'd7, 3'd7, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_COMPLEMENT, 3'd7, 3'd0, 3'd7, 3'd0, 1'b0, 32'd0);
    send_request(OP_NEGATE, 3'd2, 3'd6, 3'd0, 3'd0, 1'b0, 32'd0);
    send_request(OP_NEGATE, 3'd4, 3'd4, 3'd0, 3'd7, 1'b1, 32'd0);
    send_request(OP_NEGATE, 3'd4, 3'd4, 3'd0, 3'd7, 1'b0, 32'd0);
    send_request(OP_SUBTRACT, 3'd1, 3'd5, 3'd5, 3'd0, 1'b0, 32'd0);
    send_request(OP_SUBTRACT, 3'd2, 3'd2, 3'd6, 3'd7, 1'b1, 32'd0);
    send_request(OP_SUBTRACT, 3'd3, 3'd1, 3'd3, 3'd7, 1'b1, 32'd0);
    send_request(OP_SUBTRACT, 3'd2, 3'd2, 3'd6, 3'd7, 1'b0, 32'd0);
    send_request(OP_SUBTRACT, 3'd0, 3'd7, 3'd4, 3'd2, 1'b1, 32'd0);
    send_request(OP_AND, 3'd5, 3'd3, 3'd1, 3'd0, 1'b0, 32'd0);
    send_request(OP_OR, 3'd6, 3'd6, 3'd6, 3'd0, 1'b1, 32'd0);
    send_request(OP_OR, 3'd1, 3'd4, 3'd4, 3'd0, 1'b0, 32'd0);
    send_request(OP_OR, 3'd2, 3'd2, 3'd5, 3'd0, 1'b0, 32'd0);
    send_request(OP_OR, 3'd3, 3'd7, 3'd3, 3'd0, 1'b0, 32'd0);
    send_request(OP_OR, 3'd0, 3'd1, 3'd7, 3'd0, 1'b0, 32'd0);
    // literal forms and the edges between them
    send_request(OP_LOAD_LIT, 3'd7, 3'd0, 3'd0, 3'd0, 1'b0, 32'd0);
    send_request(OP_LOAD_LIT, 3'd1, 3'd0, 3'd0, 3'd0, 1'b0, LIT_LIMIT - 1);
    send_request(OP_LOAD_LIT, 3'd2, 3'd0, 3'd0, 3'd5, 1'b1, LIT_LIMIT);
    send_request(OP_LOAD_LIT, 3'd3, 3'd0, 3'd0, 3'd0, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_LOAD_LIT, 3'd4, 3'd0, 3'd0, 3'd0, 1'b0, 32'hFE00_0000);
    send_request(OP_LOAD_LIT, 3'd5, 3'd0, 3'd0, 3'd1, 1'b1, 32'hFDFF_FFFF);
    send_request(OP_LOAD_LIT, 3'd6, 3'd0, 3'd0, 3'd1, 1'b0, 32'h8000_0000);
    send_request(OP_LOAD_LIT, 3'd6, 3'd0, 3'd0, 3'd6, 1'b1, 32'h7FFF_FFFF);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) send_random_request();
  endtask

  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_NONE;
    in_reg_a      <= '0;
    in_reg_b      <= '0;
    in_reg_c      <= '0;
    in_temp_reg   <= '0;
    in_temp_given <= 1'b0;
    in_literal    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default opcode fields
    run_directed();
    wait_drained();

    // Extremes of the opcode fields
    set_codes(4'd0, 4'd0, 4'd0, 4'd0);
    run_phase(PHASE_ITEMS);
    wait_drained();
    set_codes(4'd15, 4'd15, 4'd15, 4'd15);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Random fields, with a full drain in the middle
    set_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_phase(PHASE_ITEMS / 2);
    wait_drained();
    run_phase(PHASE_ITEMS / 2);
    wait_drained();
    set_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Last stretch at full rate on both sides
    set_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    calm = 1'b1;
    run_phase(PHASE_ITEMS);
    wait_drained();

    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
